[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check cons in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/nsr_pkg.sv]
package nsr_pkg;

  localparam int SLOTS_DEFAULT = 256;
  localparam logic [31:0] WINDOW_RESET = 32'h0001_0000;

  localparam logic [1:0] KIND_OTHER    = 2'd0;
  localparam logic [1:0] KIND_OBJECT   = 2'd1;
  localparam logic [1:0] KIND_FUNCTION = 2'd2;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_CLEAR   = 2'd1,
    ACT_RESOLVE = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] addr;
  } entry_t;

  function automatic logic [1:0] norm_kind(input logic [1:0] k);
    logic [1:0] r;
    r = KIND_OTHER;
    if (k == KIND_OBJECT || k == KIND_FUNCTION) begin
      r = k;
    end
    return r;
  endfunction

endpackage

[rtl/core/nearest_symbol_resolver_top.sv]
// Predecessor search over a table of SYMBOL_SLOTS symbol start addresses. A write word
// is stored as it is taken; a clear word sweeps the whole table, and the same sweep
// runs once after reset before the first word is taken. A resolve word scans the table
// through one synchronous memory read at one entry per cycle, followed by one compare
// stage and one result stage. Only one word is in work at a time; a finished result
// waits in the output register while the next word is taken.
`include "assert_macros.svh"

module nearest_symbol_resolver_top #(
  parameter int SYMBOL_SLOTS = nsr_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // entry_index[7:0], symbol_address[39:8], symbol_kind[41:40], query_address[73:42]
  input  logic [79:0] s_tdata,
  // action[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // symbol_index[7:0], offset[39:8], matched_kind[41:40]
  output logic [47:0] m_tdata,
  // found[0]
  output logic        m_tuser
);

  localparam int IDX_W = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(SYMBOL_SLOTS - 1);
  localparam logic [31:0] SLOTS_32 = 32'(SYMBOL_SLOTS);

  nsr_pkg::state_t state, state_next;

  logic [7:0]  in_index;
  logic [31:0] in_addr;
  logic [1:0]  in_kind;
  logic [31:0] in_query;
  nsr_pkg::action_t in_action;
  logic        accept;

  logic [31:0]      window;
  logic [IDX_W-1:0] cnt;
  logic [31:0]      query;

  nsr_pkg::entry_t  mem [SYMBOL_SLOTS];
  nsr_pkg::entry_t  rd_data;
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  nsr_pkg::entry_t  mem_wdata;
  logic             rd_issue;
  logic             load_result;

  logic             have;
  logic [31:0]      best_addr;
  logic [IDX_W-1:0] best_idx;
  logic [1:0]       best_kind;
  logic             hit;
  logic [31:0]      diff;
  logic             match;

  assign in_index  = s_tdata[7:0];
  assign in_addr   = s_tdata[39:8];
  assign in_kind   = s_tdata[41:40];
  assign in_query  = s_tdata[73:42];
  assign in_action = nsr_pkg::action_t'(s_tuser);
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      nsr_pkg::S_CLEAR: begin
        if (cnt == LAST) state_next = nsr_pkg::S_IDLE;
      end
      nsr_pkg::S_IDLE: begin
        if (accept) begin
          case (in_action)
            nsr_pkg::ACT_RESOLVE: state_next = nsr_pkg::S_SCAN;
            nsr_pkg::ACT_CLEAR:   state_next = nsr_pkg::S_CLEAR;
            default:              state_next = nsr_pkg::S_IDLE;
          endcase
        end
      end
      nsr_pkg::S_SCAN: begin
        if (cnt == LAST) state_next = nsr_pkg::S_DRAIN;
      end
      nsr_pkg::S_DRAIN: state_next = nsr_pkg::S_FINISH;
      nsr_pkg::S_FINISH: begin
        if (!m_tvalid || m_tready) state_next = nsr_pkg::S_IDLE;
      end
      default: state_next = nsr_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cnt;
    mem_wdata   = '0;
    rd_issue    = 1'b0;
    load_result = 1'b0;
    case (state)
      nsr_pkg::S_CLEAR: mem_we = 1'b1;
      nsr_pkg::S_IDLE: begin
        s_tready  = 1'b1;
        mem_waddr = IDX_W'(in_index);
        mem_wdata = '{valid: 1'b1, kind: nsr_pkg::norm_kind(in_kind), addr: in_addr};
        mem_we    = accept && (in_action == nsr_pkg::ACT_WRITE) &&
                    ({24'd0, in_index} < SLOTS_32);
      end
      nsr_pkg::S_SCAN:   rd_issue = 1'b1;
      nsr_pkg::S_FINISH: load_result = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nsr_pkg::S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == nsr_pkg::S_IDLE) begin
        cnt <= '0;
      end else if (state == nsr_pkg::S_CLEAR || state == nsr_pkg::S_SCAN) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= nsr_pkg::WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cnt];
    rd_idx  <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
    end
  end

  assign hit = rd_pend && rd_data.valid && (rd_data.addr <= query) &&
               (!have || (rd_data.addr > best_addr));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (accept) begin
      have <= 1'b0;
    end else if (hit) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query <= in_query;
    end
    if (hit) begin
      best_addr <= rd_data.addr;
      best_idx  <= rd_idx;
      best_kind <= rd_data.kind;
    end
  end

  assign diff  = query - best_addr;
  assign match = have && (diff < window);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      m_tuser <= match;
      if (match) begin
        m_tdata <= {6'd0, best_kind, diff, 8'(best_idx)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  `ASSERT_NEXT(a_resolve_starts_scan, clk, rst,
    accept && in_action == nsr_pkg::ACT_RESOLVE,
    state == nsr_pkg::S_SCAN && cnt == '0 && !have, "resolve did not start a fresh scan")
  `ASSERT_SAME(a_miss_is_zero, clk, rst, m_tvalid && !m_tuser,
    m_tdata == '0, "miss result carries nonzero fields")
  `ASSERT_SAME(a_read_in_scan, clk, rst, rd_pend,
    state == nsr_pkg::S_SCAN || state == nsr_pkg::S_DRAIN, "read data outside a scan")

endmodule
